FILE: src/pgg_pkg.sv
// Shared constants, types and the constant log2 function of the polar Gaussian generator.
`default_nettype none
package pgg_pkg;

  localparam int UNIFORM_BITS = 16;
  localparam int SQ_W         = 2 * UNIFORM_BITS;
  localparam int SUM_W        = SQ_W + 1;
  localparam int TOP_W        = $clog2(SQ_W);
  localparam int Q_W          = 32;
  localparam int LG_W         = TOP_W + Q_W;
  localparam int G_W          = LG_W + 1;
  localparam int DIV_W        = 32;
  localparam int P_W          = DIV_W + 1;
  localparam int X2_W         = 64;
  localparam int XQ_W         = 32;
  localparam int MEAN_W       = 24;
  localparam int SIGMA_W      = 16;
  localparam int SAMPLE_W     = 24;
  localparam int LN2_W        = 24;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [LN2_W-1:0]        LN2_Q24     = 24'd11629080;
  localparam logic [UNIFORM_BITS-1:0] U_MAX       = '1;
  localparam logic [SQ_W-1:0]         M2          = {{UNIFORM_BITS{1'b0}}, U_MAX} *
                                                    {{UNIFORM_BITS{1'b0}}, U_MAX};
  localparam logic [MEAN_W-1:0]       MEAN_RESET  = 24'd20480;
  localparam logic [SIGMA_W-1:0]      SIGMA_RESET = 16'd3826;

  localparam logic REG_MEAN  = 1'b0;
  localparam logic REG_SIGMA = 1'b1;

  typedef struct packed {
    logic [SQ_W-1:0] sq_a;
    logic [SQ_W-1:0] sq_b;
    logic [SQ_W-1:0] sum;
    logic            neg_a;
    logic            neg_b;
  } attempt_t;

  function automatic logic [LG_W-1:0] log2_q32(input logic [SQ_W-1:0] x);
    logic [63:0]    m;
    logic [63:0]    sq;
    logic [Q_W-1:0] frac;
    int             e;
    e = 0;
    for (int i = 0; i < SQ_W; i++) begin
      if (x[i]) e = i;
    end
    m = 64'({x, 31'b0} >> e);
    frac = '0;
    for (int i = Q_W - 1; i >= 0; i--) begin
      sq = {32'b0, m[31:0]} * {32'b0, m[31:0]};
      m = sq >> 31;
      if (m[32]) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return {TOP_W'(e), frac};
  endfunction

  localparam logic [LG_W-1:0] LG_M2 = log2_q32(M2);

endpackage
`default_nettype wire

FILE: src/pgg_queue.sv
// Short queue of accepted attempts between the front and the back.
`default_nettype none
module pgg_queue #(
  parameter int DEPTH = pgg_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pgg_pkg::attempt_t push_data,
  output logic                   full,
  output logic                   head_valid,
  output pgg_pkg::attempt_t      head_data,
  input  wire logic              pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pgg_pkg::attempt_t mem_r [0:DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

FILE: src/pgg_front.sv
// Front: accept uniform pairs, square the offsets, drop attempts on or outside the unit circle or at its centre.
`default_nettype none
module pgg_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [pgg_pkg::UNIFORM_BITS-1:0] uniform_a,
  input  wire logic [pgg_pkg::UNIFORM_BITS-1:0] uniform_b,
  output logic                                  q_push,
  output pgg_pkg::attempt_t                     q_data,
  input  wire logic                             q_full
);

  localparam int UB   = pgg_pkg::UNIFORM_BITS;
  localparam int SQ_W = pgg_pkg::SQ_W;

  logic            f_valid_r, f_valid_nxt;
  logic [SQ_W-1:0] sq_a_r, sq_b_r;
  logic            neg_a_r, neg_b_r;
  logic            accept, f_move, keep;
  logic [UB:0]     two_a, two_b, mag_a, mag_b;
  logic            neg_a, neg_b;
  logic [pgg_pkg::SUM_W-1:0] sum;

  assign full   = f_valid_r && q_full;
  assign accept = push && !full;
  assign f_move = f_valid_r && !q_full;

  assign two_a = {uniform_a, 1'b0};
  assign two_b = {uniform_b, 1'b0};
  assign neg_a = two_a < {1'b0, pgg_pkg::U_MAX};
  assign neg_b = two_b < {1'b0, pgg_pkg::U_MAX};
  assign mag_a = neg_a ? ({1'b0, pgg_pkg::U_MAX} - two_a) : (two_a - {1'b0, pgg_pkg::U_MAX});
  assign mag_b = neg_b ? ({1'b0, pgg_pkg::U_MAX} - two_b) : (two_b - {1'b0, pgg_pkg::U_MAX});

  assign sum  = {1'b0, sq_a_r} + {1'b0, sq_b_r};
  assign keep = (sum != '0) && (sum < {1'b0, pgg_pkg::M2});

  assign q_push       = f_move && keep;
  assign q_data.sq_a  = sq_a_r;
  assign q_data.sq_b  = sq_b_r;
  assign q_data.sum   = sum[SQ_W-1:0];
  assign q_data.neg_a = neg_a_r;
  assign q_data.neg_b = neg_b_r;

  always_comb begin
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (f_move) begin
      f_valid_nxt = 1'b0;
    end else begin
      f_valid_nxt = f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_a_r  <= {{UB{1'b0}}, mag_a[UB-1:0]} * {{UB{1'b0}}, mag_a[UB-1:0]};
      sq_b_r  <= {{UB{1'b0}}, mag_b[UB-1:0]} * {{UB{1'b0}}, mag_b[UB-1:0]};
      neg_a_r <= neg_a;
      neg_b_r <= neg_b;
    end
  end

endmodule
`default_nettype wire

FILE: src/pgg_back.sv
// Back: per-sample pipeline for log, divide, root, scale and saturate.
`default_nettype none
module pgg_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  input  wire pgg_pkg::attempt_t                   q_data,
  output logic                                     q_pop,
  input  wire logic signed [pgg_pkg::MEAN_W-1:0]   mean,
  input  wire logic [pgg_pkg::SIGMA_W-1:0]         sigma,
  input  wire logic                                pop,
  output logic                                     empty,
  output logic signed [pgg_pkg::SAMPLE_W-1:0]      sample,
  output logic                                     last
);

  localparam int SQ_W  = pgg_pkg::SQ_W;
  localparam int TOP_W = pgg_pkg::TOP_W;
  localparam int DIV_W = pgg_pkg::DIV_W;
  localparam int P_W   = pgg_pkg::P_W;
  localparam int LG_W  = pgg_pkg::LG_W;
  localparam int G_W   = pgg_pkg::G_W;
  localparam int X2_W  = pgg_pkg::X2_W;
  localparam int XQ_W  = pgg_pkg::XQ_W;
  localparam int NL    = P_W;
  localparam int NS    = XQ_W;
  localparam int PP_W  = P_W - 8;
  localparam int PR_W  = pgg_pkg::SIGMA_W + XQ_W + 1;
  localparam int MAG_W = PR_W - 28;
  localparam int T_W   = pgg_pkg::SAMPLE_W + 2;

  typedef struct packed {
    logic last;
    logic neg;
  } tag_t;

  logic adv, phase_r;

  logic            s0_valid_r, s1_valid_r;
  tag_t            s0_tag_r, s1_tag_r;
  logic [SQ_W-1:0] s0_nsq_r, s0_sum_r, s1_nsq_r, s1_sum_r;
  logic [TOP_W-1:0] s1_top_r, top;

  logic [TOP_W:0]       bl, k;
  logic [DIV_W-1:0]     a_sh, b_sh;
  logic [DIV_W-1:0]     s2_a_r;

  logic              lane_valid_r [0:NL];
  tag_t              lane_tag_r   [0:NL];
  logic [TOP_W-1:0]  lane_top_r   [0:NL];
  logic [31:0]       lane_m_r     [0:NL];
  logic [31:0]       lane_m_nxt   [1:NL];
  logic [31:0]       lane_frac_r  [0:NL];
  logic [31:0]       lane_frac_nxt[1:NL];
  logic [DIV_W-1:0]  lane_b_r     [0:NL];
  logic [DIV_W-1:0]  lane_rem_r   [0:NL];
  logic [DIV_W-1:0]  lane_rem_nxt [1:NL];
  logic [P_W-1:0]    lane_p_r     [0:NL];
  logic [P_W-1:0]    lane_p_nxt   [1:NL];

  logic            g1_valid_r, g2_valid_r, g3_valid_r;
  tag_t            g1_tag_r, g2_tag_r, g3_tag_r;
  logic [LG_W-1:0] g1_l_r;
  logic [PP_W-1:0] g1_pp_r, g2_pp_r;
  logic [G_W-1:0]  g2_g_r;
  logic [X2_W-1:0] g3_x_r;
  logic [LG_W+pgg_pkg::LN2_W-1:0] g_prod;

  logic             sq_valid_r [0:NS];
  tag_t             sq_tag_r   [0:NS];
  logic [X2_W-1:0]  sq_x_r     [0:NS];
  logic [X2_W-1:0]  sq_x_nxt   [1:NS];
  logic [X2_W-1:0]  sq_r_r     [0:NS];
  logic [X2_W-1:0]  sq_r_nxt   [1:NS];

  logic            f1_valid_r, out_valid_r;
  tag_t            f1_tag_r;
  logic [PR_W-1:0] f1_prod_r;
  logic signed [T_W-1:0] t_sum;
  logic signed [pgg_pkg::SAMPLE_W-1:0] sample_r, sat;
  logic            last_r;

  assign adv    = !out_valid_r || pop;
  assign q_pop  = adv && q_valid && phase_r;
  assign empty  = !out_valid_r;
  assign sample = sample_r;
  assign last   = last_r;

  always_comb begin
    top = '0;
    for (int i = 0; i < SQ_W; i++) begin
      if (s0_sum_r[i]) top = TOP_W'(i);
    end
  end

  always_comb begin
    bl = {1'b0, s1_top_r} + (TOP_W+1)'(1);
    k  = (int'(bl) > DIV_W) ? (bl - (TOP_W+1)'(DIV_W)) : '0;
    a_sh = DIV_W'(s1_nsq_r >> k);
    b_sh = DIV_W'(s1_sum_r >> k);
    if (a_sh > b_sh) a_sh = b_sh;
  end

  always_comb begin
    logic [63:0] sq;
    logic [32:0] sh;
    logic [DIV_W:0] rr;
    sq = '0;
    sh = '0;
    rr = '0;
    for (int j = 1; j <= NL; j++) begin
      lane_m_nxt[j]    = lane_m_r[j-1];
      lane_frac_nxt[j] = lane_frac_r[j-1];
      lane_rem_nxt[j]  = lane_rem_r[j-1];
      lane_p_nxt[j]    = lane_p_r[j-1];
      if (j == 1) begin
        if (s2_a_r >= lane_b_r[0]) begin
          lane_rem_nxt[j]     = s2_a_r - lane_b_r[0];
          lane_p_nxt[j][NL-1] = 1'b1;
        end else begin
          lane_rem_nxt[j] = s2_a_r;
        end
      end else begin
        sq = {32'b0, lane_m_r[j-1]} * {32'b0, lane_m_r[j-1]};
        sh = sq[63:31];
        if (sh[32]) begin
          lane_m_nxt[j]          = sh[32:1];
          lane_frac_nxt[j][NL-j] = 1'b1;
        end else begin
          lane_m_nxt[j] = sh[31:0];
        end
        rr = {lane_rem_r[j-1], 1'b0};
        if (rr >= {1'b0, lane_b_r[j-1]}) begin
          lane_rem_nxt[j]     = DIV_W'(rr - {1'b0, lane_b_r[j-1]});
          lane_p_nxt[j][NL-j] = 1'b1;
        end else begin
          lane_rem_nxt[j] = rr[DIV_W-1:0];
        end
      end
    end
  end

  assign g_prod = {{pgg_pkg::LN2_W{1'b0}}, g1_l_r} * {{LG_W{1'b0}}, pgg_pkg::LN2_Q24};

  always_comb begin
    logic [X2_W-1:0] bit_v;
    logic [X2_W-1:0] trial;
    bit_v = '0;
    trial = '0;
    for (int j = 1; j <= NS; j++) begin
      bit_v = X2_W'(1) << (X2_W - 2 * j);
      trial = sq_r_r[j-1] + bit_v;
      if (sq_x_r[j-1] >= trial) begin
        sq_x_nxt[j] = sq_x_r[j-1] - trial;
        sq_r_nxt[j] = (sq_r_r[j-1] >> 1) + bit_v;
      end else begin
        sq_x_nxt[j] = sq_x_r[j-1];
        sq_r_nxt[j] = sq_r_r[j-1] >> 1;
      end
    end
  end

  always_comb begin
    t_sum = f1_tag_r.neg ? (T_W'(mean) - $signed({{(T_W-MAG_W){1'b0}}, f1_prod_r[PR_W-1:28]}))
                         : (T_W'(mean) + $signed({{(T_W-MAG_W){1'b0}}, f1_prod_r[PR_W-1:28]}));
    if (t_sum > T_W'(signed'({1'b0, {(pgg_pkg::SAMPLE_W-1){1'b1}}}))) begin
      sat = {1'b0, {(pgg_pkg::SAMPLE_W-1){1'b1}}};
    end else if (t_sum < T_W'(signed'({1'b1, {(pgg_pkg::SAMPLE_W-1){1'b0}}}))) begin
      sat = {1'b1, {(pgg_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      sat = t_sum[pgg_pkg::SAMPLE_W-1:0];
    end
  end

  // valid chain and issue phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      g1_valid_r  <= 1'b0;
      g2_valid_r  <= 1'b0;
      g3_valid_r  <= 1'b0;
      f1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= NL; j++) lane_valid_r[j] <= 1'b0;
      for (int j = 0; j <= NS; j++) sq_valid_r[j] <= 1'b0;
    end else if (adv) begin
      if (q_valid) phase_r <= !phase_r;
      s0_valid_r      <= q_valid;
      s1_valid_r      <= s0_valid_r;
      lane_valid_r[0] <= s1_valid_r;
      for (int j = 1; j <= NL; j++) lane_valid_r[j] <= lane_valid_r[j-1];
      g1_valid_r      <= lane_valid_r[NL];
      g2_valid_r      <= g1_valid_r;
      g3_valid_r      <= g2_valid_r;
      sq_valid_r[0]   <= g3_valid_r;
      for (int j = 1; j <= NS; j++) sq_valid_r[j] <= sq_valid_r[j-1];
      f1_valid_r      <= sq_valid_r[NS];
      out_valid_r     <= f1_valid_r;
    end
  end

  // datapath, advanced with the valid chain
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_tag_r.last <= phase_r;
      s0_tag_r.neg  <= phase_r ? q_data.neg_b : q_data.neg_a;
      s0_nsq_r      <= phase_r ? q_data.sq_b : q_data.sq_a;
      s0_sum_r      <= q_data.sum;

      s1_tag_r <= s0_tag_r;
      s1_nsq_r <= s0_nsq_r;
      s1_sum_r <= s0_sum_r;
      s1_top_r <= top;

      lane_tag_r[0]  <= s1_tag_r;
      lane_top_r[0]  <= s1_top_r;
      lane_m_r[0]    <= 32'({s1_sum_r, 31'b0} >> s1_top_r);
      lane_frac_r[0] <= '0;
      lane_b_r[0]    <= b_sh;
      lane_rem_r[0]  <= '0;
      lane_p_r[0]    <= '0;
      s2_a_r         <= a_sh;
      for (int j = 1; j <= NL; j++) begin
        lane_tag_r[j]  <= lane_tag_r[j-1];
        lane_top_r[j]  <= lane_top_r[j-1];
        lane_b_r[j]    <= lane_b_r[j-1];
        lane_m_r[j]    <= lane_m_nxt[j];
        lane_frac_r[j] <= lane_frac_nxt[j];
        lane_rem_r[j]  <= lane_rem_nxt[j];
        lane_p_r[j]    <= lane_p_nxt[j];
      end

      g1_tag_r <= lane_tag_r[NL];
      g1_l_r   <= pgg_pkg::LG_M2 - {lane_top_r[NL], lane_frac_r[NL]};
      g1_pp_r  <= lane_p_r[NL][P_W-1:8];
      g2_tag_r <= g1_tag_r;
      g2_pp_r  <= g1_pp_r;
      g2_g_r   <= g_prod[LG_W+pgg_pkg::LN2_W-1:23];
      g3_tag_r <= g2_tag_r;
      g3_x_r   <= {{(X2_W-PP_W){1'b0}}, g2_pp_r} * {{(X2_W-G_W){1'b0}}, g2_g_r};

      sq_tag_r[0] <= g3_tag_r;
      sq_x_r[0]   <= g3_x_r;
      sq_r_r[0]   <= '0;
      for (int j = 1; j <= NS; j++) begin
        sq_tag_r[j] <= sq_tag_r[j-1];
        sq_x_r[j]   <= sq_x_nxt[j];
        sq_r_r[j]   <= sq_r_nxt[j];
      end

      f1_tag_r  <= sq_tag_r[NS];
      f1_prod_r <= {{(PR_W-pgg_pkg::SIGMA_W){1'b0}}, sigma} *
                   {{(PR_W-XQ_W){1'b0}}, sq_r_r[NS][XQ_W-1:0]} + PR_W'(1 << 27);

      sample_r <= sat;
      last_r   <= f1_tag_r.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> q_valid) else $error("second sample issued without its attempt");
`endif

endmodule
`default_nettype wire

FILE: src/polar_gaussian_generator.sv
// Top level: configuration registers, front, attempt queue and sample pipeline.
//
//   channel  | handshake      | beat
//   input    | push / full    | in_uniform_a, in_uniform_b
//   result   | empty / pop    | out_sample, out_last
//   config   | psel / penable | paddr, pwdata, prdata (mean at 0, sigma at 4)
//
// One pair of uniforms may be taken each cycle; every kept pair yields two samples,
// and the sample pipeline moves one sample per cycle unless a held result stalls it;
// a pair is popped with its second sample. The pipeline holds the 33-stage log/divide
// lanes and the 32-stage square root. Reset clears all valid state and loads mean and sigma defaults.
// A held result freezes the whole sample pipeline; the queue then fills and raises full.
`default_nettype none
module polar_gaussian_generator #(
  parameter int QUEUE_DEPTH = pgg_pkg::QUEUE_DEPTH
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [pgg_pkg::UNIFORM_BITS-1:0]     in_uniform_a,
  input  wire logic [pgg_pkg::UNIFORM_BITS-1:0]     in_uniform_b,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [pgg_pkg::SAMPLE_W-1:0]       out_sample,
  output logic                                      out_last,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pgg_pkg::ADDR_W-1:0]           paddr,
  input  wire logic [pgg_pkg::DATA_W-1:0]           pwdata,
  output logic [pgg_pkg::DATA_W-1:0]                prdata,
  output logic                                      pready
);

  logic [pgg_pkg::MEAN_W-1:0]  mean_r;
  logic [pgg_pkg::SIGMA_W-1:0] sigma_r;
  logic                        q_push, q_full, q_valid, q_pop;
  pgg_pkg::attempt_t           q_wdata, q_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= pgg_pkg::MEAN_RESET;
      sigma_r <= pgg_pkg::SIGMA_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        pgg_pkg::REG_MEAN:  mean_r  <= pwdata[pgg_pkg::MEAN_W-1:0];
        pgg_pkg::REG_SIGMA: sigma_r <= pwdata[pgg_pkg::SIGMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pgg_pkg::REG_MEAN:  prdata = pgg_pkg::DATA_W'(mean_r);
      pgg_pkg::REG_SIGMA: prdata = pgg_pkg::DATA_W'(sigma_r);
      default:            prdata = '0;
    endcase
  end

  pgg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .uniform_a (in_uniform_a),
    .uniform_b (in_uniform_b),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  pgg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_rdata),
    .pop        (q_pop)
  );

  pgg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .mean    (signed'(mean_r)),
    .sigma   (sigma_r),
    .pop     (pop),
    .empty   (empty),
    .sample  (out_sample),
    .last    (out_last)
  );

endmodule
`default_nettype wire

FILE: tb/pgg_checker.sv
// Checker for the polar Gaussian generator: predicts samples from accepted uniform pairs.
`default_nettype none
module pgg_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              push,
  input  wire logic                              full,
  input  wire logic [pgg_pkg::UNIFORM_BITS-1:0]  in_uniform_a,
  input  wire logic [pgg_pkg::UNIFORM_BITS-1:0]  in_uniform_b,
  input  wire logic                              empty,
  input  wire logic                              pop,
  input  wire logic [pgg_pkg::SAMPLE_W-1:0]      out_sample,
  input  wire logic                              out_last,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic                              pready,
  input  wire logic [pgg_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [pgg_pkg::DATA_W-1:0]        pwdata,
  output int                                     fail_count,
  output int                                     pending
);
  import pgg_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } sample_beat_t;

  sample_beat_t         expected_samples[$];
  logic [MEAN_W-1:0]    mean_q;
  logic [SIGMA_W-1:0]   sigma_q;

  function automatic int msb_index(input logic [63:0] x);
    int e;
    e = 0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) e = i;
    end
    return e;
  endfunction

  function automatic logic [63:0] log2_fixed(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] frac;
    int          e;
    e = msb_index(x);
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    frac = '0;
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[i] = 1'b1;
      end
    end
    return (64'(e) << 32) | frac;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] gauss_sample(input logic [63:0] nsq, input logic neg,
                                                       input logic [63:0] sum,
                                                       input logic [63:0] g);
    int          k;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] p;
    logic [63:0] xq;
    logic [63:0] mag;
    longint      t;
    k = msb_index(sum) + 1 - 32;
    if (k < 0) k = 0;
    a = nsq >> k;
    b = sum >> k;
    if (a > b) a = b;
    p = (a << 32) / b;
    xq = int_sqrt((p >> 8) * g);
    mag = ((64'(sigma_q) * xq) + (64'd1 << 27)) >> 28;
    t = longint'($signed(mean_q));
    t = neg ? t - longint'(mag) : t + longint'(mag);
    if (t > 64'sh7FFFFF) t = 64'sh7FFFFF;
    if (t < -64'sh800000) t = -64'sh800000;
    return t[SAMPLE_W-1:0];
  endfunction

  task automatic predict_pair(input logic [UNIFORM_BITS-1:0] ua, input logic [UNIFORM_BITS-1:0] ub);
    longint      n1;
    longint      n2;
    logic [63:0] s1;
    logic [63:0] s2;
    logic [63:0] m2;
    logic [63:0] sum;
    logic [63:0] g;
    sample_beat_t beat;
    m2 = 64'(U_MAX) * 64'(U_MAX);
    n1 = 2 * longint'(ua) - longint'(U_MAX);
    n2 = 2 * longint'(ub) - longint'(U_MAX);
    s1 = n1 * n1;
    s2 = n2 * n2;
    sum = s1 + s2;
    if (sum >= m2 || sum == 0) return;
    g = ((log2_fixed(m2) - log2_fixed(sum)) * 64'(LN2_Q24)) >> 23;
    beat.sample = gauss_sample(s1, n1 < 0, sum, g);
    beat.last = 1'b0;
    expected_samples.push_back(beat);
    beat.sample = gauss_sample(s2, n2 < 0, sum, g);
    beat.last = 1'b1;
    expected_samples.push_back(beat);
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    sample_beat_t want;
    if (!rst_n) begin
      mean_q <= MEAN_RESET;
      sigma_q <= SIGMA_RESET;
      expected_samples.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_samples.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected sample beat: sample=%0d last=%0b",
                     $signed(out_sample), out_last);
        end else begin
          want = expected_samples.pop_front();
          if (want.sample !== out_sample || want.last !== out_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("sample mismatch: expected %0d/%0b, got %0d/%0b",
                       $signed(want.sample), want.last, $signed(out_sample), out_last);
          end
        end
      end
      if (push && !full) predict_pair(in_uniform_a, in_uniform_b);
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[2] == REG_MEAN) mean_q <= pwdata[MEAN_W-1:0];
        else if (paddr[2] == REG_SIGMA) sigma_q <= pwdata[SIGMA_W-1:0];
      end
    end
    pending = expected_samples.size();
  end

endmodule
`default_nettype wire

FILE: tb/polar_gaussian_generator_tb.sv
// Testbench top: drives uniform pairs and register writes, checks via pgg_checker.
`default_nettype none
module polar_gaussian_generator_tb;
  import pgg_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  logic [UNIFORM_BITS-1:0] in_uniform_a = '0;
  logic [UNIFORM_BITS-1:0] in_uniform_b = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic [SAMPLE_W-1:0]     out_sample;
  logic                    out_last;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  int                      fail_count;
  int                      pending;
  bit                      gaps_on = 1'b1;
  int                      hold_cycles = 0;

  polar_gaussian_generator i_dut (
    .clk, .rst_n, .push, .full, .in_uniform_a, .in_uniform_b, .empty, .pop,
    .out_sample, .out_last, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pgg_checker i_checker (
    .clk, .rst_n, .push, .full, .in_uniform_a, .in_uniform_b, .empty, .pop,
    .out_sample, .out_last, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        pop <= 1'b0;
        hold_cycles--;
      end else begin
        pop <= gaps_on ? ($urandom_range(99) >= 9) : 1'b1;
      end
    end
  end

  task automatic send_pair(input logic [UNIFORM_BITS-1:0] ua, input logic [UNIFORM_BITS-1:0] ub);
    while (gaps_on && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_uniform_a <= ua;
    in_uniform_b <= ub;
    do @(posedge clk); while (full);
  endtask

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_pairs(input int count);
    logic [UNIFORM_BITS-1:0] ua;
    logic [UNIFORM_BITS-1:0] ub;
    for (int i = 0; i < count; i++) begin
      ua = UNIFORM_BITS'($urandom);
      ub = UNIFORM_BITS'($urandom);
      // bias some pairs to the center: tiny S, large samples
      if ($urandom_range(9) == 0) begin
        ua = 16'd32767 + 16'($urandom_range(40));
        ub = 16'd32767 + 16'($urandom_range(40));
      end
      send_pair(ua, ub);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners, rejections and the near-zero radius
    send_pair(16'd0, 16'd0);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'd0, 16'd32768);
    send_pair(16'd32767, 16'd32768);
    send_pair(16'd32768, 16'd32768);
    send_pair(16'd32767, 16'd32767);
    send_pair(16'd32768, 16'd0);
    send_pair(16'hFFFF, 16'd32768);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'd10000, 16'd55535);
    send_pair(16'd9598, 16'd9598);
    send_pair(16'd9599, 16'd9599);
    random_pairs(250);
    drain();

    write_reg(REG_MEAN, 32'h0);
    write_reg(REG_SIGMA, 32'd4096);
    hold_cycles = 400;
    random_pairs(250);
    drain();

    write_reg(REG_MEAN, 32'hFF80_0000);
    write_reg(REG_SIGMA, 32'hFFFF_FFFF);
    gaps_on = 1'b0;
    send_pair(16'd32767, 16'd32768);
    send_pair(16'd32768, 16'd32767);
    random_pairs(250);
    gaps_on = 1'b1;
    drain();

    write_reg(REG_MEAN, 32'h007F_FFFF);
    write_reg(REG_SIGMA, 32'hFFFF);
    send_pair(16'd32768, 16'd32768);
    random_pairs(250);
    drain();

    write_reg(REG_MEAN, $urandom);
    write_reg(REG_SIGMA, 32'h0);
    random_pairs(250);
    drain();

    write_reg(REG_MEAN, $urandom);
    write_reg(REG_SIGMA, $urandom);
    random_pairs(250);
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: polar_gaussian_generator.f
src/pgg_pkg.sv
src/pgg_queue.sv
src/pgg_front.sv
src/pgg_back.sv
src/polar_gaussian_generator.sv
tb/pgg_checker.sv
tb/polar_gaussian_generator_tb.sv
